/* sv/bb3s_pkg.sv */
// Shared types and constants of the streaming 3x3 box blur.
`default_nettype none

package bb3s_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_DATA_W     = 13;

   localparam int SUM_W = 12;

   localparam int DIV6_MUL    = 5462;
   localparam int DIV6_SHIFT  = 15;
   localparam int DIV18_MUL   = 3641;
   localparam int DIV18_SHIFT = 16;

   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 4);

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_BY_4 = 2'd0,
      DIV_BY_6 = 2'd1,
      DIV_BY_9 = 2'd2
   } div_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_item_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_item_type;

   typedef struct packed {
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_item_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type lower;
      logic      live;
   } line_word_type;

   typedef struct packed {
      logic top;
      logic bot;
      logic left;
      logic right;
      logic last;
   } hood_type;

   typedef struct packed {
      logic      live;
      pixel_type pix;
      logic      fill_ok;
      logic      restart;
      hood_type  hood;
   } slot_type;

endpackage

`default_nettype wire

/* sv/bb3s_chan_if.sv */
// Valid/ready channel carrying one payload item per handshake.
`default_nettype none

interface bb3s_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/bb3s_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module bb3s_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

/* sv/box_blur_3x3_stream_top.sv */
// Streaming 3x3 box blur of RGB pixels with two line stores and a 3x3 window.
//
// Requests arrive on req_if in raster order: a pixel request carries one RGB
// pixel, a drain request pushes an empty slot to flush one pending result.
// Each result on rsp_if is the rounded mean of the pixel's in-image 3x3
// neighborhood per channel; frame_end marks the last pixel of a frame.
// csr_if writes frame_width (index 0) or frame_height (index 1) and restarts
// the stream; write it only while the block is idle.
// Throughput: one request per cycle while req_if.ready is high, set by the
// single read-modify-write of the line store RAM per request. A result is
// offered on rsp_if once the request width+1 places later in the stream is
// accepted and has passed stages 1 to 3 into the result queue.
// An eight-entry result queue decouples rsp_if: requests keep flowing while a
// result waits, and req_if.ready drops only once the queue plus the three
// stages in flight reach eight.
// Reset: synchronous, active high; width 640, height 480, stream at row 0,
// column 0 with nothing pending. The line store needs no clearing pass.
`default_nettype none

module box_blur_3x3_stream_top #(
   parameter int MAX_WIDTH  = bb3s_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bb3s_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bb3s_chan_if.sink   req_if,
   bb3s_chan_if.source rsp_if,
   bb3s_chan_if.sink   csr_if
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WV = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int HV = $clog2(MAX_HEIGHT + 1);
   localparam int PW = $clog2(MAX_WIDTH + 2);
   localparam int RST_W = (bb3s_pkg::WIDTH_RESET > MAX_WIDTH) ?
                          MAX_WIDTH : bb3s_pkg::WIDTH_RESET;
   localparam int RST_H = (bb3s_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                          MAX_HEIGHT : bb3s_pkg::HEIGHT_RESET;
   localparam int LINE_W = $bits(bb3s_pkg::line_word_type);

   // configuration
   logic                                  csr_fire;
   logic [bb3s_pkg::FRAME_WIDTH_W-1:0]    csr_fw;
   logic [bb3s_pkg::FRAME_HEIGHT_W-1:0]   csr_fh;
   logic [WV-1:0]                         width_ff, width_in;
   logic [HV-1:0]                         height_ff, height_in;

   // stream position and bookkeeping
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [WV-1:0] fill_ff, fill_in;
   logic [PW-1:0] pending_ff, pending_in;
   logic [PW-1:0] pend_less, pend_after;
   logic          req_fire, is_drain, enter, prev_mid, restart_now, fill_ok;
   logic          col_last, row_last;
   bb3s_pkg::hood_type hood;

   // stage 1: line store read and window shift
   logic                    s1_valid_ff, s1_valid_in;
   bb3s_pkg::slot_type      s1_ff, s1_in;
   logic [CW-1:0]           s1_col_ff;
   logic [LINE_W-1:0]       ram_rdata;
   bb3s_pkg::line_word_type rd_word, wr_word;
   logic                    s1_mid;
   bb3s_pkg::pixel_type     win_ff [3][3];
   logic [2:0]              wv_ff, wv_in;

   // stage 2: masked sums
   logic                         s2_valid_ff, s2_valid_in;
   logic                         s2_emit_ff, s2_emit_in;
   bb3s_pkg::hood_type           s2_hood_ff;
   logic [2:0]                   row_use, col_use;
   logic [2:0][bb3s_pkg::SUM_W-1:0] sum_in, s3_sum_ff;
   bb3s_pkg::div_type            div_in, s3_div_ff;

   // stage 3: divide into the result queue
   logic                   s3_valid_ff, s3_valid_in;
   logic                   s3_emit_ff, s3_emit_in;
   logic                   s3_last_ff;
   bb3s_pkg::rsp_item_type push_item;
   bb3s_pkg::rsp_item_type fifo_ff [bb3s_pkg::OUT_DEPTH];
   logic [bb3s_pkg::OUT_PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [bb3s_pkg::OUT_CNT_W-1:0] count_ff, count_in, occupancy;
   logic                   fifo_push, fifo_pop;

   function automatic logic [7:0] div_round(input logic [bb3s_pkg::SUM_W-1:0] sum,
                                            input bb3s_pkg::div_type div);
      logic [bb3s_pkg::SUM_W-1:0] q4;
      logic [12:0]                x6;
      logic [12:0]                x18;
      logic [25:0]                p6;
      logic [25:0]                p18;
      logic [11:0]                q;
      q4  = (sum + bb3s_pkg::SUM_W'(2)) >> 2;
      x6  = 13'(sum) + 13'd3;
      x18 = {sum, 1'b0} + 13'd9;
      p6  = 26'(x6) * 26'(bb3s_pkg::DIV6_MUL);
      p18 = 26'(x18) * 26'(bb3s_pkg::DIV18_MUL);
      case (div)
         bb3s_pkg::DIV_BY_4: q = 12'(q4);
         bb3s_pkg::DIV_BY_6: q = 12'(p6 >> bb3s_pkg::DIV6_SHIFT);
         bb3s_pkg::DIV_BY_9: q = 12'(p18 >> bb3s_pkg::DIV18_SHIFT);
         default:            q = '0;
      endcase
      return (q > 12'd255) ? 8'hFF : q[7:0];
   endfunction

   // configuration writes, clamped to the supported frame size
   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid && csr_if.ready;
   assign csr_fw       = csr_if.payload.wdata[bb3s_pkg::FRAME_WIDTH_W-1:0];
   assign csr_fh       = csr_if.payload.wdata[bb3s_pkg::FRAME_HEIGHT_W-1:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_fire) begin
         case (csr_if.payload.index)
            bb3s_pkg::CSR_FRAME_WIDTH: begin
               if (32'(csr_fw) < 2) begin
                  width_in = WV'(2);
               end else if (32'(csr_fw) > MAX_WIDTH) begin
                  width_in = WV'(MAX_WIDTH);
               end else begin
                  width_in = WV'(csr_fw);
               end
            end
            bb3s_pkg::CSR_FRAME_HEIGHT: begin
               if (32'(csr_fh) < 2) begin
                  height_in = HV'(2);
               end else if (32'(csr_fh) > MAX_HEIGHT) begin
                  height_in = HV'(MAX_HEIGHT);
               end else begin
                  height_in = HV'(csr_fh);
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // line store: upper and lower rows plus the live mark of the lower row
   assign rd_word       = ram_rdata;
   assign s1_mid        = rd_word.live && s1_ff.fill_ok;
   assign wr_word.upper = rd_word.lower;
   assign wr_word.lower = s1_ff.pix;
   assign wr_word.live  = s1_ff.live;

   bb3s_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock    (clock),
      .we       (s1_valid_ff),
      .waddr    (s1_col_ff),
      .wdata    (wr_word),
      .raddr    (col_ff),
      .rdata_ff (ram_rdata)
   );

   // stage 0: accept, pending count, position and neighborhood flags
   assign req_fire = req_if.valid && req_if.ready;
   assign is_drain = req_if.payload.req_type == bb3s_pkg::REQ_DRAIN;
   assign prev_mid = s1_valid_ff ? (s1_mid && !s1_ff.restart) : wv_ff[2];
   assign enter    = req_fire && (!is_drain || pending_ff != '0);
   assign fill_ok  = fill_ff == width_ff;
   assign col_last = WV'(col_ff) + WV'(1) == width_ff;
   assign row_last = HV'(row_ff) + HV'(1) == height_ff;

   always_comb begin
      pend_less = pending_ff;
      if (prev_mid && pending_ff != '0) begin
         pend_less = pending_ff - PW'(1);
      end
      pend_after  = pend_less + PW'(!is_drain);
      restart_now = is_drain && pend_after == '0;
   end

   always_comb begin
      hood.left  = (col_ff != '0) ? (32'(col_ff) >= 2) : 1'b1;
      hood.right = col_ff != '0;
      if (col_ff != '0) begin
         hood.top  = row_ff != RW'(1);
         hood.bot  = row_ff != '0;
         hood.last = 1'b0;
      end else begin
         hood.top  = (32'(row_ff) >= 3) || (row_ff == RW'(1)) ||
                     (row_ff == '0 && height_ff != HV'(2));
         hood.bot  = row_ff != RW'(1);
         hood.last = row_ff == RW'(1);
      end
   end

   always_comb begin
      s1_in.live    = !is_drain;
      s1_in.pix     = is_drain ? '0 : {req_if.payload.red_in, req_if.payload.green_in,
                                       req_if.payload.blue_in};
      s1_in.fill_ok = fill_ok;
      s1_in.restart = restart_now;
      s1_in.hood    = hood;
   end

   // control next state
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      fill_in     = fill_ff;
      pending_in  = pending_ff;
      wv_in       = wv_ff;
      s1_valid_in = enter;
      s2_valid_in = s1_valid_ff;
      s2_emit_in  = s1_valid_ff && wv_ff[2];
      s3_valid_in = s2_valid_ff;
      s3_emit_in  = s2_valid_ff && s2_emit_ff;
      if (s1_valid_ff) begin
         if (s1_ff.restart) begin
            wv_in = '0;
         end else begin
            wv_in = {s1_mid, wv_ff[2], wv_ff[1]};
         end
      end
      if (enter) begin
         pending_in = pend_after;
         if (restart_now) begin
            col_in  = '0;
            row_in  = '0;
            fill_in = '0;
         end else begin
            fill_in = fill_ok ? fill_ff : fill_ff + WV'(1);
            if (col_last) begin
               col_in = '0;
               row_in = row_last ? '0 : row_ff + RW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
      end
      if (csr_fire) begin
         col_in      = '0;
         row_in      = '0;
         fill_in     = '0;
         pending_in  = '0;
         wv_in       = '0;
         s1_valid_in = 1'b0;
         s2_valid_in = 1'b0;
         s2_emit_in  = 1'b0;
         s3_valid_in = 1'b0;
         s3_emit_in  = 1'b0;
      end
   end

   // stage 2: masked neighborhood sums and divisor choice
   always_comb begin
      row_use = {s2_hood_ff.bot, 1'b1, s2_hood_ff.top};
      col_use = {s2_hood_ff.right, 1'b1, s2_hood_ff.left};
      sum_in  = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (row_use[r] && col_use[c]) begin
               sum_in[0] = sum_in[0] + bb3s_pkg::SUM_W'(win_ff[r][c].red);
               sum_in[1] = sum_in[1] + bb3s_pkg::SUM_W'(win_ff[r][c].green);
               sum_in[2] = sum_in[2] + bb3s_pkg::SUM_W'(win_ff[r][c].blue);
            end
         end
      end
      case ({s2_hood_ff.top && s2_hood_ff.bot, s2_hood_ff.left && s2_hood_ff.right})
         2'b11:   div_in = bb3s_pkg::DIV_BY_9;
         2'b00:   div_in = bb3s_pkg::DIV_BY_4;
         default: div_in = bb3s_pkg::DIV_BY_6;
      endcase
   end

   // stage 3 and result queue
   always_comb begin
      push_item.red_out   = div_round(s3_sum_ff[0], s3_div_ff);
      push_item.green_out = div_round(s3_sum_ff[1], s3_div_ff);
      push_item.blue_out  = div_round(s3_sum_ff[2], s3_div_ff);
      push_item.frame_end = s3_last_ff;
   end

   assign fifo_push = s3_valid_ff && s3_emit_ff;
   assign fifo_pop  = rsp_if.valid && rsp_if.ready;

   always_comb begin
      head_in  = fifo_pop ? head_ff + bb3s_pkg::OUT_PTR_W'(1) : head_ff;
      tail_in  = fifo_push ? tail_ff + bb3s_pkg::OUT_PTR_W'(1) : tail_ff;
      count_in = count_ff + bb3s_pkg::OUT_CNT_W'(fifo_push) -
                 bb3s_pkg::OUT_CNT_W'(fifo_pop);
      occupancy = count_ff + bb3s_pkg::OUT_CNT_W'(s1_valid_ff) +
                  bb3s_pkg::OUT_CNT_W'(s2_valid_ff) + bb3s_pkg::OUT_CNT_W'(s3_valid_ff);
   end

   assign req_if.ready   = occupancy < bb3s_pkg::OUT_CNT_W'(bb3s_pkg::OUT_DEPTH);
   assign rsp_if.valid   = count_ff != '0;
   assign rsp_if.payload = fifo_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WV'(RST_W);
         height_ff   <= HV'(RST_H);
         col_ff      <= '0;
         row_ff      <= '0;
         fill_ff     <= '0;
         pending_ff  <= '0;
         wv_ff       <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_emit_ff  <= 1'b0;
         s3_valid_ff <= 1'b0;
         s3_emit_ff  <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         fill_ff     <= fill_in;
         pending_ff  <= pending_in;
         wv_ff       <= wv_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s2_emit_ff  <= s2_emit_in;
         s3_valid_ff <= s3_valid_in;
         s3_emit_ff  <= s3_emit_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff     <= s1_in;
      s1_col_ff <= col_ff;
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= rd_word.upper;
         win_ff[1][2] <= rd_word.lower;
         win_ff[2][2] <= s1_ff.pix;
      end
      s2_hood_ff <= s1_ff.hood;
      s3_sum_ff  <= sum_in;
      s3_div_ff  <= div_in;
      s3_last_ff <= s2_hood_ff.last;
      if (fifo_push) begin
         fifo_ff[tail_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire
